[design/rll_pkg.sv]
// Shared types and constants for the RGB to log-LMS lightness/alpha/beta pipeline.
// Holds the pixel and result word types, weights, log table and scale factors.
// No dependencies.
package rll_pkg;

  localparam int FRAC_BITS = 12;

  localparam int CH_W  = 8;
  localparam int WGT_W = 16;
  localparam int P_W   = 24;
  localparam int E_W   = 5;
  localparam int F_W   = P_W - 1;
  localparam int K_W   = 5;
  localparam int R_W   = F_W - K_W;
  localparam int M_W   = 16;
  localparam int LG_W  = 32;
  localparam int NUM_CH = 3;
  localparam int TAB_N  = 33;

  localparam int L_W = 17;
  localparam int A_W = 16;
  localparam int B_W = 16;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rll_in_t;

  typedef struct packed {
    logic signed [L_W-1:0] lightness;
    logic signed [A_W-1:0] alpha;
    logic signed [B_W-1:0] beta;
  } rll_out_t;

  typedef logic [P_W-1:0]         rll_p_t;
  typedef logic signed [LG_W-1:0] rll_lg_t;

  localparam logic [WGT_W-1:0] WGT [NUM_CH][NUM_CH] = '{
    '{16'd24976, 16'd37899, 16'd2635},
    '{16'd12891, 16'd47474, 16'd5125},
    '{16'd1579,  16'd8441,  16'd55338}
  };

  localparam logic [M_W-1:0] LN_TAB [TAB_N] = '{
    16'd0,     16'd2017,  16'd3973,  16'd5873,  16'd7719,  16'd9515,  16'd11262, 16'd12965,
    16'd14624, 16'd16242, 16'd17821, 16'd19364, 16'd20870, 16'd22343, 16'd23783, 16'd25193,
    16'd26573, 16'd27924, 16'd29248, 16'd30546, 16'd31818, 16'd33067, 16'd34292, 16'd35494,
    16'd36675, 16'd37835, 16'd38975, 16'd40095, 16'd41196, 16'd42280, 16'd43345, 16'd44394,
    16'd45426
  };

  localparam logic signed [LG_W-1:0] LN2_Q24        = 32'sd11629080;
  localparam logic signed [LG_W-1:0] LN_256_255_Q24 = 32'sd65664;

  localparam int FAC_W = 17;
  localparam logic signed [FAC_W-1:0] INV_SQRT3_Q16 = 17'sd37837;
  localparam logic signed [FAC_W-1:0] INV_SQRT6_Q16 = 17'sd26755;
  localparam logic signed [FAC_W-1:0] INV_SQRT2_Q16 = 17'sd46341;

endpackage

[design/rll_lms.sv]
// Weighted sum stage: forms the L, M and S sums of one pixel word.
// Depends on rll_pkg.
module rll_lms (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  rll_pkg::rll_in_t      word_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output rll_pkg::rll_p_t       p_o [rll_pkg::NUM_CH]
);
  import rll_pkg::*;

  logic   valid_q;
  logic   hold;
  rll_p_t p_d [NUM_CH];
  rll_p_t p_q [NUM_CH];

  assign hold    = valid_q & stall_i;
  assign stall_o = hold;
  assign valid_o = valid_q;

  always_comb begin
    logic [CH_W-1:0]  c [NUM_CH];
    logic [P_W+1:0]   acc;
    c[0] = word_i.red;
    c[1] = word_i.green;
    c[2] = word_i.blue;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = '0;
      for (int j = 0; j < NUM_CH; j++) begin
        acc = acc + (P_W+2)'(WGT[ch][j]) * (P_W+2)'(c[j]);
      end
      p_d[ch] = acc[P_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!hold) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[design/rll_log.sv]
// Three-stage natural log unit for the three LMS lanes: leading one and normalize,
// table interpolation, exponent scaling. Depends on rll_pkg.
module rll_log (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  rll_pkg::rll_p_t   p_i [rll_pkg::NUM_CH],
  output logic              valid_o,
  input  logic              stall_i,
  output rll_pkg::rll_lg_t  lg_o [rll_pkg::NUM_CH]
);
  import rll_pkg::*;

  localparam int NST = 3;

  logic [NST-1:0] valid_q;
  logic [NST-1:0] hold;

  logic [E_W-1:0] e1_q [NUM_CH];
  logic [F_W-1:0] f1_q [NUM_CH];
  logic           z1_q [NUM_CH];
  logic [E_W-1:0] e2_q [NUM_CH];
  logic [M_W-1:0] m2_q [NUM_CH];
  logic           z2_q [NUM_CH];
  rll_lg_t        lg3_q [NUM_CH];

  logic [E_W-1:0] e1_d [NUM_CH];
  logic [F_W-1:0] f1_d [NUM_CH];
  logic [M_W-1:0] m2_d [NUM_CH];
  rll_lg_t        lg3_d [NUM_CH];

  always_comb begin
    hold[NST-1] = valid_q[NST-1] & stall_i;
    for (int s = NST-2; s >= 0; s--) begin
      hold[s] = valid_q[s] & hold[s+1];
    end
  end

  assign stall_o = hold[0];
  assign valid_o = valid_q[NST-1];

  always_comb begin
    logic [P_W-1:0] n;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      e1_d[ch] = '0;
      for (int b = 0; b < P_W; b++) begin
        if (p_i[ch][b]) begin
          e1_d[ch] = E_W'(b);
        end
      end
      n = p_i[ch] << (E_W'(P_W-1) - e1_d[ch]);
      f1_d[ch] = n[F_W-1:0];
    end
  end

  always_comb begin
    logic [K_W-1:0]     k;
    logic [R_W-1:0]     r;
    logic [M_W-1:0]     a;
    logic [M_W-1:0]     b;
    logic [M_W-1:0]     diff;
    logic [R_W+10:0]    prod;
    logic [R_W+10:0]    rnd;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      k    = f1_q[ch][F_W-1:R_W];
      r    = f1_q[ch][R_W-1:0];
      a    = LN_TAB[{1'b0, k}];
      b    = LN_TAB[{1'b0, k} + 6'd1];
      diff = b - a;
      prod = diff[10:0] * r;
      rnd  = (prod + (R_W+11)'(1 << (R_W-1))) >> R_W;
      m2_d[ch] = a + M_W'(rnd);
    end
  end

  always_comb begin
    logic signed [E_W:0]  ev;
    rll_lg_t              ev_w;
    rll_lg_t              m_w;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      ev   = $signed({1'b0, e2_q[ch]}) - 6'sd24;
      ev_w = {{(LG_W-E_W-1){ev[E_W]}}, ev};
      m_w  = $signed({{(LG_W-M_W-8){1'b0}}, m2_q[ch], 8'b0});
      lg3_d[ch] = z2_q[ch] ? '0 : (ev_w * LN2_Q24 + m_w + LN_256_255_Q24);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (!hold[0]) valid_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) begin
        if (!hold[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (!hold[0]) begin
        e1_q[ch] <= e1_d[ch];
        f1_q[ch] <= f1_d[ch];
        z1_q[ch] <= (p_i[ch] == '0);
      end
      if (!hold[1]) begin
        e2_q[ch] <= e1_q[ch];
        m2_q[ch] <= m2_d[ch];
        z2_q[ch] <= z1_q[ch];
      end
      if (!hold[2]) begin
        lg3_q[ch] <= lg3_d[ch];
      end
    end
  end

  assign lg_o = lg3_q;

endmodule

[design/rll_mix.sv]
// Output stages: combine the three logs, scale by the inverse square roots,
// round to nearest with ties away from zero and saturate. Depends on rll_pkg.
module rll_mix (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              stall_o,
  input  rll_pkg::rll_lg_t  lg_i [rll_pkg::NUM_CH],
  output logic              valid_o,
  input  logic              stall_i,
  output rll_pkg::rll_out_t word_o
);
  import rll_pkg::*;

  localparam int NST    = 3;
  localparam int SUM_W  = LG_W + 2;
  localparam int PROD_W = SUM_W + FAC_W;
  localparam int SH     = 40 - FRAC_BITS;

  localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (SH - 1);

  localparam logic signed [FAC_W-1:0] FAC [NUM_CH] = '{
    INV_SQRT3_Q16, INV_SQRT6_Q16, INV_SQRT2_Q16
  };
  localparam logic signed [PROD_W-1:0] LO [NUM_CH] = '{
    -PROD_W'(65536), -PROD_W'(32768), -PROD_W'(32768)
  };
  localparam logic signed [PROD_W-1:0] HI [NUM_CH] = '{
    PROD_W'(0), PROD_W'(32767), PROD_W'(32767)
  };

  logic [NST-1:0] valid_q;
  logic [NST-1:0] hold;

  logic signed [SUM_W-1:0]  sum_d  [NUM_CH];
  logic signed [SUM_W-1:0]  sum_q  [NUM_CH];
  logic signed [PROD_W-1:0] prod_d [NUM_CH];
  logic signed [PROD_W-1:0] prod_q [NUM_CH];
  logic signed [PROD_W-1:0] sat_d  [NUM_CH];
  rll_out_t                 word_d;
  rll_out_t                 word_q;

  always_comb begin
    hold[NST-1] = valid_q[NST-1] & stall_i;
    for (int s = NST-2; s >= 0; s--) begin
      hold[s] = valid_q[s] & hold[s+1];
    end
  end

  assign stall_o = hold[0];
  assign valid_o = valid_q[NST-1];

  always_comb begin
    logic signed [SUM_W-1:0] l0;
    logic signed [SUM_W-1:0] l1;
    logic signed [SUM_W-1:0] l2;
    l0 = {{(SUM_W-LG_W){lg_i[0][LG_W-1]}}, lg_i[0]};
    l1 = {{(SUM_W-LG_W){lg_i[1][LG_W-1]}}, lg_i[1]};
    l2 = {{(SUM_W-LG_W){lg_i[2][LG_W-1]}}, lg_i[2]};
    sum_d[0] = l0 + l1 + l2;
    sum_d[1] = l0 + l1 - (l2 <<< 1);
    sum_d[2] = l0 - l1;
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod_d[ch] = sum_q[ch] * FAC[ch];
    end
  end

  always_comb begin
    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        rnd;
    logic signed [PROD_W-1:0] val;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      neg = prod_q[ch][PROD_W-1];
      mag = neg ? -prod_q[ch] : prod_q[ch];
      rnd = (mag + HALF) >> SH;
      val = neg ? -$signed(rnd) : $signed(rnd);
      if (val < LO[ch]) begin
        sat_d[ch] = LO[ch];
      end else if (val > HI[ch]) begin
        sat_d[ch] = HI[ch];
      end else begin
        sat_d[ch] = val;
      end
    end
    word_d.lightness = sat_d[0][L_W-1:0];
    word_d.alpha     = sat_d[1][A_W-1:0];
    word_d.beta      = sat_d[2][B_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (!hold[0]) valid_q[0] <= valid_i;
      for (int s = 1; s < NST; s++) begin
        if (!hold[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!hold[0]) sum_q  <= sum_d;
    if (!hold[1]) prod_q <= prod_d;
    if (!hold[2]) word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

[design/rgb_to_log_lab_pixel.sv]
// Top level of the RGB to log-LMS lightness/alpha/beta converter.
// Depends on rll_pkg, rll_lms, rll_log and rll_mix.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o / in_word_i carry one RGB pixel word
//   (red, green, blue bytes). A word is taken on a rising edge with valid high
//   and stall low.
//   Output channel: out_valid_o / out_stall_i / out_word_o carry lightness,
//   alpha and beta, signed with FRAC_BITS fraction bits.
//   Pipeline: 7 register stages (1 weighted sum stage, 3 log stages,
//   3 combine/scale/round stages).
//   Throughput: one pixel per cycle while out_stall_i is low; every stage is a
//   plain register step; the scale stage multiplies 34-bit sums by 17-bit factors.
//   Reset: rst_ni clears all stage valid bits; the pipeline comes up empty and
//   ready at once.
//   Stall: while out_stall_i holds a finished word, upstream stages keep
//   filling empty slots; in_stall_o rises only once every stage is full.
//   Nothing is dropped or repeated.
module rgb_to_log_lab_pixel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rll_pkg::rll_in_t   in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rll_pkg::rll_out_t  out_word_o
);
  import rll_pkg::*;

  logic    lms_valid;
  logic    lms_stall;
  rll_p_t  lms_p [NUM_CH];
  logic    log_valid;
  logic    log_stall;
  rll_lg_t log_lg [NUM_CH];

  rll_lms u_lms (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .word_i  (in_word_i),
    .valid_o (lms_valid),
    .stall_i (lms_stall),
    .p_o     (lms_p)
  );

  rll_log u_log (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lms_valid),
    .stall_o (lms_stall),
    .p_i     (lms_p),
    .valid_o (log_valid),
    .stall_i (log_stall),
    .lg_o    (log_lg)
  );

  rll_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (log_valid),
    .stall_o (log_stall),
    .lg_i    (log_lg),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (out_word_o)
  );

endmodule
